FILE: hdl/mer_pkg.sv
`timescale 1ns / 1ps

package mer_pkg;

   localparam int COORD_BITS = 12;
   localparam int AXIS_BITS  = COORD_BITS - 1;
   localparam int SQ_BITS    = 2 * AXIS_BITS;
   localparam int OPND_BITS  = 2 * COORD_BITS + 2;
   localparam int PROD_BITS  = 2 * OPND_BITS;
   localparam int DEC_BITS   = PROD_BITS + 4;
   localparam int RGB_BITS   = 24;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   // multiplier operand selection
   localparam logic [3:0] MUL_NONE = 4'd0;
   localparam logic [3:0] MUL_AA   = 4'd1;
   localparam logic [3:0] MUL_BB   = 4'd2;
   localparam logic [3:0] MUL_INIT = 4'd3;
   localparam logic [3:0] MUL_B4   = 4'd4;
   localparam logic [3:0] MUL_T1   = 4'd5;
   localparam logic [3:0] MUL_T2   = 4'd6;
   localparam logic [3:0] MUL_R1P  = 4'd7;
   localparam logic [3:0] MUL_R1Q  = 4'd8;
   localparam logic [3:0] MUL_SQX  = 4'd9;
   localparam logic [3:0] MUL_SQY  = 4'd10;
   localparam logic [3:0] MUL_BSQ  = 4'd11;
   localparam logic [3:0] MUL_ASQ  = 4'd12;
   localparam logic [3:0] MUL_AB   = 4'd13;
   localparam logic [3:0] MUL_R2P  = 4'd14;
   localparam logic [3:0] MUL_R2Q  = 4'd15;

   // what to do with the registered product
   localparam logic [3:0] ACC_NONE     = 4'd0;
   localparam logic [3:0] ACC_LDA      = 4'd1;
   localparam logic [3:0] ACC_LDB      = 4'd2;
   localparam logic [3:0] ACC_S_LD     = 4'd3;
   localparam logic [3:0] ACC_S_ADD4   = 4'd4;
   localparam logic [3:0] ACC_CMP      = 4'd5;
   localparam logic [3:0] ACC_SQ       = 4'd6;
   localparam logic [3:0] ACC_D_SP     = 4'd7;
   localparam logic [3:0] ACC_D_ADD4P  = 4'd8;
   localparam logic [3:0] ACC_D_ADD4SP = 4'd9;
   localparam logic [3:0] ACC_D_SSUB4P = 4'd10;

   localparam logic [2:0] PIX_TOP = 3'd0;
   localparam logic [2:0] PIX_PP  = 3'd1;
   localparam logic [2:0] PIX_PM  = 3'd2;
   localparam logic [2:0] PIX_MP  = 3'd3;
   localparam logic [2:0] PIX_MM  = 3'd4;

   typedef struct packed {
      logic                  mode;
      logic [COORD_BITS-1:0] corner_ax;
      logic [COORD_BITS-1:0] corner_ay;
      logic [COORD_BITS-1:0] corner_bx;
      logic [COORD_BITS-1:0] corner_by;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [RGB_BITS-1:0]   pixel_rgb;
      logic                  last_of_run;
      logic                  finished;
   } rsp_type;

   typedef struct packed {
      logic       load_item;
      logic [3:0] mul_op;
      logic [3:0] acc_op;
      logic       inc_x;
      logic       dec_y;
      logic       set_r2;
      logic       clr_active;
      logic       emit;
      logic [2:0] pix_sel;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic item_mode;
      logic active;
      logic region_two;
      logic test_lt;
      logic dec_neg;
      logic y_zero;
      logic out_free;
   } sts_type;

endpackage

FILE: hdl/mer_datapath.sv
`timescale 1ns / 1ps

module mer_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mer_pkg::cmd_type              cmd,
   output mer_pkg::sts_type              sts,
   input  mer_pkg::req_type              req_data,
   input  logic                          csr_wr_en,
   input  logic [mer_pkg::RGB_BITS-1:0]  csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mer_pkg::rsp_type              rsp_data
);

   localparam int CW  = mer_pkg::COORD_BITS;
   localparam int AW  = mer_pkg::AXIS_BITS;
   localparam int SQW = mer_pkg::SQ_BITS;
   localparam int OW  = mer_pkg::OPND_BITS;
   localparam int PW  = mer_pkg::PROD_BITS;
   localparam int DW  = mer_pkg::DEC_BITS;

   localparam logic signed [OW-1:0] K0 = OW'(0);
   localparam logic signed [OW-1:0] K1 = OW'(1);
   localparam logic signed [OW-1:0] K2 = OW'(2);
   localparam logic signed [OW-1:0] K3 = OW'(3);
   localparam logic signed [OW-1:0] K4 = OW'(4);

   logic [mer_pkg::RGB_BITS-1:0] color_ff;
   logic [CW-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [AW-1:0]  a_ff, a_in, b_ff, b_in;
   logic [SQW-1:0] asq_ff, asq_in, bsq_ff, bsq_in;
   logic [CW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [DW-1:0] d_ff, d_in, s_ff, s_in;
   logic signed [OW-1:0] sq_ff, sq_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic lt_ff, lt_in;
   logic active_ff, active_in;
   logic r2_ff, r2_in;
   logic rsp_valid_ff;
   mer_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // start geometry
   logic [CW:0]   sum_x, sum_y;
   logic [CW-1:0] dx, dy;
   logic [AW-1:0] a_new, b_new;

   assign sum_x = {1'b0, req_data.corner_ax} + {1'b0, req_data.corner_bx};
   assign sum_y = {1'b0, req_data.corner_ay} + {1'b0, req_data.corner_by};
   assign dx = (req_data.corner_ax > req_data.corner_bx) ?
               req_data.corner_ax - req_data.corner_bx :
               req_data.corner_bx - req_data.corner_ax;
   assign dy = (req_data.corner_ay > req_data.corner_by) ?
               req_data.corner_ay - req_data.corner_by :
               req_data.corner_by - req_data.corner_ay;
   assign a_new = dx[CW-1:1];
   assign b_new = dy[CW-1:1];

   // shared multiplier operands
   logic signed [OW-1:0] xe, ye, ae, be, ase, bse, two_x, two_y, opa, opb;
   assign xe  = signed'({{(OW-CW){1'b0}}, x_ff});
   assign ye  = signed'({{(OW-CW){1'b0}}, y_ff});
   assign ae  = signed'({{(OW-AW){1'b0}}, a_ff});
   assign be  = signed'({{(OW-AW){1'b0}}, b_ff});
   assign ase = signed'({{(OW-SQW){1'b0}}, asq_ff});
   assign bse = signed'({{(OW-SQW){1'b0}}, bsq_ff});
   assign two_x = xe <<< 1;
   assign two_y = ye <<< 1;

   always_comb begin
      opa = K0;
      opb = K0;
      case (cmd.mul_op)
         mer_pkg::MUL_AA: begin
            opa = ae;  opb = ae;
         end
         mer_pkg::MUL_BB: begin
            opa = be;  opb = be;
         end
         mer_pkg::MUL_INIT: begin
            opa = ase; opb = K1 - (be <<< 2);
         end
         mer_pkg::MUL_B4: begin
            opa = bse; opb = K4;
         end
         mer_pkg::MUL_T1: begin
            opa = bse; opb = two_x + K2;
         end
         mer_pkg::MUL_T2: begin
            opa = ase; opb = two_y - K1;
         end
         mer_pkg::MUL_R1P: begin
            opa = bse; opb = two_x + K3;
         end
         mer_pkg::MUL_R1Q: begin
            opa = ase; opb = K2 - two_y;
         end
         mer_pkg::MUL_SQX: begin
            opa = two_x + K1; opb = two_x + K1;
         end
         mer_pkg::MUL_SQY: begin
            opa = ye - K1; opb = ye - K1;
         end
         mer_pkg::MUL_BSQ: begin
            opa = bse; opb = sq_ff;
         end
         mer_pkg::MUL_ASQ: begin
            opa = ase; opb = sq_ff;
         end
         mer_pkg::MUL_AB: begin
            opa = ase; opb = bse;
         end
         mer_pkg::MUL_R2P: begin
            opa = bse; opb = two_x + K2;
         end
         mer_pkg::MUL_R2Q: begin
            opa = ase; opb = K3 - two_y;
         end
         default: begin
            opa = K0;  opb = K0;
         end
      endcase
   end

   assign prod_in = opa * opb;

   logic signed [DW-1:0] prod_x;
   assign prod_x = signed'({{(DW-PW){prod_ff[PW-1]}}, prod_ff});

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      asq_in    = asq_ff;
      bsq_in    = bsq_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      s_in      = s_ff;
      sq_in     = sq_ff;
      lt_in     = lt_ff;
      active_in = active_ff;
      r2_in     = r2_ff;

      if (cmd.load_item && req_data.mode == mer_pkg::MODE_START) begin
         cx_in     = sum_x[CW:1];
         cy_in     = sum_y[CW:1];
         a_in      = a_new;
         b_in      = b_new;
         x_in      = '0;
         y_in      = {{(CW-AW){1'b0}}, b_new};
         r2_in     = 1'b0;
         active_in = (b_new != '0);
      end

      case (cmd.acc_op)
         mer_pkg::ACC_LDA:      asq_in = prod_ff[SQW-1:0];
         mer_pkg::ACC_LDB:      bsq_in = prod_ff[SQW-1:0];
         mer_pkg::ACC_S_LD:     s_in   = prod_x;
         mer_pkg::ACC_S_ADD4:   s_in   = s_ff + (prod_x <<< 2);
         mer_pkg::ACC_CMP:      lt_in  = (s_ff < prod_x);
         mer_pkg::ACC_SQ:       sq_in  = prod_ff[OW-1:0];
         mer_pkg::ACC_D_SP:     d_in   = s_ff + prod_x;
         mer_pkg::ACC_D_ADD4P:  d_in   = d_ff + (prod_x <<< 2);
         mer_pkg::ACC_D_ADD4SP: d_in   = d_ff + ((s_ff + prod_x) <<< 2);
         mer_pkg::ACC_D_SSUB4P: d_in   = s_ff - (prod_x <<< 2);
         default: ;
      endcase

      if (cmd.inc_x) begin
         x_in = x_ff + CW'(1);
      end
      if (cmd.dec_y) begin
         y_in = y_ff - CW'(1);
         // the step that reaches the axis closes the outline
         if (y_ff == CW'(1)) begin
            active_in = 1'b0;
         end
      end
      if (cmd.set_r2) begin
         r2_in = 1'b1;
      end
      if (cmd.clr_active) begin
         active_in = 1'b0;
      end
   end

   // pixel selection for the output register
   always_comb begin
      rsp_data_in.pixel_rgb   = color_ff;
      rsp_data_in.last_of_run = cmd.last;
      rsp_data_in.finished    = (y_ff == '0);
      case (cmd.pix_sel)
         mer_pkg::PIX_PP: begin
            rsp_data_in.pixel_x = cx_ff + x_ff;
            rsp_data_in.pixel_y = cy_ff + y_ff;
         end
         mer_pkg::PIX_PM: begin
            rsp_data_in.pixel_x = cx_ff + x_ff;
            rsp_data_in.pixel_y = cy_ff - y_ff;
         end
         mer_pkg::PIX_MP: begin
            rsp_data_in.pixel_x = cx_ff - x_ff;
            rsp_data_in.pixel_y = cy_ff + y_ff;
         end
         mer_pkg::PIX_MM: begin
            rsp_data_in.pixel_x = cx_ff - x_ff;
            rsp_data_in.pixel_y = cy_ff - y_ff;
         end
         default: begin
            rsp_data_in.pixel_x  = cx_ff;
            rsp_data_in.pixel_y  = cy_ff + {{(CW-AW){1'b0}}, b_ff};
            rsp_data_in.finished = (b_ff == '0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= '0;
         active_ff    <= 1'b0;
         r2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            color_ff <= csr_wr_data;
         end
         active_ff <= active_in;
         r2_ff     <= r2_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      asq_ff  <= asq_in;
      bsq_ff  <= bsq_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      d_ff    <= d_in;
      s_ff    <= s_in;
      sq_ff   <= sq_in;
      lt_ff   <= lt_in;
      prod_ff <= prod_in;
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign sts.item_mode  = req_data.mode;
   assign sts.active     = active_ff;
   assign sts.region_two = r2_ff;
   assign sts.test_lt    = lt_ff;
   assign sts.dec_neg    = d_ff[DW-1];
   assign sts.y_zero     = (y_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

FILE: hdl/mer_ctrl.sv
`timescale 1ns / 1ps

module mer_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mer_pkg::sts_type sts,
   output mer_pkg::cmd_type cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_ST1   = 5'd1;
   localparam logic [4:0] S_ST2   = 5'd2;
   localparam logic [4:0] S_ST3   = 5'd3;
   localparam logic [4:0] S_ST4   = 5'd4;
   localparam logic [4:0] S_ST5   = 5'd5;
   localparam logic [4:0] S_ETOP  = 5'd6;
   localparam logic [4:0] S_R1_0  = 5'd7;
   localparam logic [4:0] S_R1_1  = 5'd8;
   localparam logic [4:0] S_R1_2  = 5'd9;
   localparam logic [4:0] S_R1_3  = 5'd10;
   localparam logic [4:0] S_R1_N  = 5'd11;
   localparam logic [4:0] S_R1_Y  = 5'd12;
   localparam logic [4:0] S_R1_Y2 = 5'd13;
   localparam logic [4:0] S_R2I_0 = 5'd14;
   localparam logic [4:0] S_R2I_1 = 5'd15;
   localparam logic [4:0] S_R2I_2 = 5'd16;
   localparam logic [4:0] S_R2I_3 = 5'd17;
   localparam logic [4:0] S_R2I_4 = 5'd18;
   localparam logic [4:0] S_R2I_5 = 5'd19;
   localparam logic [4:0] S_R2I_6 = 5'd20;
   localparam logic [4:0] S_R2I_7 = 5'd21;
   localparam logic [4:0] S_R2_0  = 5'd22;
   localparam logic [4:0] S_R2_Y  = 5'd23;
   localparam logic [4:0] S_R2_N  = 5'd24;
   localparam logic [4:0] S_R2_N2 = 5'd25;
   localparam logic [4:0] S_EM0   = 5'd26;
   localparam logic [4:0] S_EM1   = 5'd27;
   localparam logic [4:0] S_EM2   = 5'd28;
   localparam logic [4:0] S_EM3   = 5'd29;

   logic [4:0] st_ff, st_in;

   always_comb begin
      st_in     = st_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (st_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (sts.item_mode == mer_pkg::MODE_START) begin
                  st_in = S_ST1;
               end else if (!sts.active) begin
                  st_in = S_IDLE;
               end else if (sts.region_two) begin
                  st_in = S_R2_0;
               end else begin
                  st_in = S_R1_0;
               end
            end
         end
         // start: a^2, b^2, d = 4b^2 + a^2(1-4b)
         S_ST1: begin
            cmd.mul_op = mer_pkg::MUL_AA;
            st_in = S_ST2;
         end
         S_ST2: begin
            cmd.acc_op = mer_pkg::ACC_LDA;
            cmd.mul_op = mer_pkg::MUL_BB;
            st_in = S_ST3;
         end
         S_ST3: begin
            cmd.acc_op = mer_pkg::ACC_LDB;
            cmd.mul_op = mer_pkg::MUL_INIT;
            st_in = S_ST4;
         end
         S_ST4: begin
            cmd.acc_op = mer_pkg::ACC_S_LD;
            cmd.mul_op = mer_pkg::MUL_B4;
            st_in = S_ST5;
         end
         S_ST5: begin
            cmd.acc_op = mer_pkg::ACC_D_SP;
            st_in = S_ETOP;
         end
         S_ETOP: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.pix_sel = mer_pkg::PIX_TOP;
               cmd.last    = 1'b1;
               st_in = S_IDLE;
            end
         end
         // region one: test 2b^2(x+1) < a^2(2y-1)
         S_R1_0: begin
            cmd.mul_op = mer_pkg::MUL_T1;
            st_in = S_R1_1;
         end
         S_R1_1: begin
            cmd.acc_op = mer_pkg::ACC_S_LD;
            cmd.mul_op = mer_pkg::MUL_T2;
            st_in = S_R1_2;
         end
         S_R1_2: begin
            cmd.acc_op = mer_pkg::ACC_CMP;
            st_in = S_R1_3;
         end
         S_R1_3: begin
            if (sts.test_lt) begin
               cmd.mul_op = mer_pkg::MUL_R1P;
               st_in = sts.dec_neg ? S_R1_N : S_R1_Y;
            end else begin
               cmd.set_r2 = 1'b1;
               st_in = S_R2I_0;
            end
         end
         S_R1_N: begin
            cmd.acc_op = mer_pkg::ACC_D_ADD4P;
            cmd.inc_x  = 1'b1;
            st_in = S_EM0;
         end
         S_R1_Y: begin
            cmd.acc_op = mer_pkg::ACC_S_LD;
            cmd.mul_op = mer_pkg::MUL_R1Q;
            st_in = S_R1_Y2;
         end
         S_R1_Y2: begin
            cmd.acc_op = mer_pkg::ACC_D_ADD4SP;
            cmd.inc_x  = 1'b1;
            cmd.dec_y  = 1'b1;
            st_in = S_EM0;
         end
         // region two seed: b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2b^2
         S_R2I_0: begin
            cmd.mul_op = mer_pkg::MUL_SQX;
            st_in = S_R2I_1;
         end
         S_R2I_1: begin
            cmd.acc_op = mer_pkg::ACC_SQ;
            st_in = S_R2I_2;
         end
         S_R2I_2: begin
            cmd.mul_op = mer_pkg::MUL_BSQ;
            st_in = S_R2I_3;
         end
         S_R2I_3: begin
            cmd.acc_op = mer_pkg::ACC_S_LD;
            cmd.mul_op = mer_pkg::MUL_SQY;
            st_in = S_R2I_4;
         end
         S_R2I_4: begin
            cmd.acc_op = mer_pkg::ACC_SQ;
            st_in = S_R2I_5;
         end
         S_R2I_5: begin
            cmd.mul_op = mer_pkg::MUL_ASQ;
            st_in = S_R2I_6;
         end
         S_R2I_6: begin
            cmd.acc_op = mer_pkg::ACC_S_ADD4;
            cmd.mul_op = mer_pkg::MUL_AB;
            st_in = S_R2I_7;
         end
         S_R2I_7: begin
            cmd.acc_op = mer_pkg::ACC_D_SSUB4P;
            st_in = S_R2_0;
         end
         S_R2_0: begin
            if (sts.y_zero) begin
               cmd.clr_active = 1'b1;
               st_in = S_IDLE;
            end else begin
               cmd.mul_op = mer_pkg::MUL_R2Q;
               st_in = sts.dec_neg ? S_R2_N : S_R2_Y;
            end
         end
         S_R2_Y: begin
            cmd.acc_op = mer_pkg::ACC_D_ADD4P;
            cmd.dec_y  = 1'b1;
            st_in = S_EM0;
         end
         S_R2_N: begin
            cmd.acc_op = mer_pkg::ACC_S_LD;
            cmd.mul_op = mer_pkg::MUL_R2P;
            st_in = S_R2_N2;
         end
         S_R2_N2: begin
            cmd.acc_op = mer_pkg::ACC_D_ADD4SP;
            cmd.inc_x  = 1'b1;
            cmd.dec_y  = 1'b1;
            st_in = S_EM0;
         end
         S_EM0: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.pix_sel = mer_pkg::PIX_PP;
               st_in = S_EM1;
            end
         end
         S_EM1: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.pix_sel = mer_pkg::PIX_PM;
               st_in = S_EM2;
            end
         end
         S_EM2: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.pix_sel = mer_pkg::PIX_MP;
               st_in = S_EM3;
            end
         end
         S_EM3: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.pix_sel = mer_pkg::PIX_MM;
               cmd.last    = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

FILE: hdl/midpoint_ellipse_rasterizer.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   req_data   (mer_pkg::req_type)
// rsp      out        rsp_valid/rsp_ready   rsp_data   (mer_pkg::rsp_type)
// csr      in         csr_wr_en             csr_wr_data (pixel color)
//
// One item at a time through a single shared 26x26 multiplier with a registered
// product; its sequence of dependent products sets the cycle count.
// Synchronous active-high reset clears the sequencer, active/region flags,
// output valid and the color register. A stalled rsp holds the sequencer.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  mer_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mer_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [mer_pkg::RGB_BITS-1:0] csr_wr_data
);

   mer_pkg::cmd_type cmd;
   mer_pkg::sts_type sts;

   mer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mer_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: hdl/mer_checker.sv
`timescale 1ns / 1ps

module mer_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mer_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mer_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // a start transfer always launches the multiply sequence
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == mer_pkg::MODE_START |=> !req_ready)
      else $error("ready after start transfer");

   // mid-run pixels never coexist with an idle input side
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> !req_ready)
      else $error("ready while a pixel run is open");

   a_run_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_run |=> rsp_valid)
      else $error("gap inside a pixel run");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);

FILE: tb/sv/ellipse_pixel_checker.sv
`timescale 1ns / 1ps

module ellipse_pixel_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  mer_pkg::req_type             req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  mer_pkg::rsp_type             rsp_data,
   input  logic                         csr_wr_en,
   input  logic [mer_pkg::RGB_BITS-1:0] csr_wr_data,
   output int                           error_count,
   output int                           pixels_pending
);

   localparam int DECISION_BITS = 52;
   localparam int CW   = mer_pkg::COORD_BITS;
   localparam int SQW  = mer_pkg::SQ_BITS;
   localparam int RGBW = mer_pkg::RGB_BITS;

   // shadow of the rasterizer state
   logic [RGBW-1:0]                 color;
   logic [CW-1:0]                   mid_x;
   logic [CW-1:0]                   mid_y;
   logic [SQW-1:0]                  a_sq;
   logic [SQW-1:0]                  b_sq;
   logic [CW-1:0]                   walk_x;
   logic [CW-1:0]                   walk_y;
   logic signed [DECISION_BITS-1:0] decision;
   logic                            region_two;
   logic                            tracing;

   mer_pkg::rsp_type pending_pixels[$];
   mer_pkg::rsp_type oldest;

   function automatic void queue_pixel(input logic [CW-1:0] px, py,
                                       input logic last, fin);
      mer_pkg::rsp_type p;
      p.pixel_x     = px;
      p.pixel_y     = py;
      p.pixel_rgb   = color;
      p.last_of_run = last;
      p.finished    = fin;
      pending_pixels.push_back(p);
   endfunction

   // Decision terms are kept at four times their real value so all of this is exact.
   function automatic void rasterize_item(input mer_pkg::req_type item);
      int            ax, ay, bx, by, semi_a, semi_b;
      longint        sa, sb, x, y, d;
      logic          advanced;
      logic          fin;
      logic [CW-1:0] ox, oy;
      if (item.mode == mer_pkg::MODE_START) begin
         ax = int'(item.corner_ax);
         ay = int'(item.corner_ay);
         bx = int'(item.corner_bx);
         by = int'(item.corner_by);
         semi_a = (ax > bx ? ax - bx : bx - ax) / 2;
         semi_b = (ay > by ? ay - by : by - ay) / 2;
         mid_x = CW'((ax + bx) >> 1);
         mid_y = CW'((ay + by) >> 1);
         a_sq = SQW'(semi_a * semi_a);
         b_sq = SQW'(semi_b * semi_b);
         sa = longint'(a_sq);
         sb = longint'(b_sq);
         walk_x = '0;
         walk_y = CW'(semi_b);
         decision = DECISION_BITS'(4 * sb + sa * (1 - 4 * semi_b));
         region_two = 1'b0;
         tracing = (semi_b != 0);
         oy = CW'(semi_b);
         queue_pixel(mid_x, mid_y + oy, 1'b1, semi_b == 0);
         return;
      end
      if (!tracing)
         return;

      sa = longint'(a_sq);
      sb = longint'(b_sq);
      x = longint'(walk_x);
      y = longint'(walk_y);
      d = longint'(decision);
      advanced = 1'b0;
      if (!region_two) begin
         if (2 * sb * (x + 1) < sa * (2 * y - 1)) begin
            if (d < 0) begin
               d += 4 * sb * (2 * x + 3);
            end else begin
               d += 4 * (sb * (2 * x + 3) + sa * (2 - 2 * y));
               y--;
            end
            x++;
            advanced = 1'b1;
         end else begin
            region_two = 1'b1;
            d = sb * (2 * x + 1) * (2 * x + 1) + 4 * sa * (y - 1) * (y - 1) - 4 * sa * sb;
         end
      end
      if (!advanced) begin
         // already at the bottom: nothing left to draw
         if (y <= 0) begin
            tracing = 1'b0;
            return;
         end
         if (d < 0) begin
            d += 4 * (sb * (2 * x + 2) + sa * (3 - 2 * y));
            x++;
         end else begin
            d += 4 * sa * (3 - 2 * y);
         end
         y--;
      end

      walk_x = CW'(x);
      walk_y = CW'(y);
      decision = DECISION_BITS'(d);
      fin = (y <= 0);
      if (fin)
         tracing = 1'b0;
      ox = walk_x;
      oy = walk_y;
      queue_pixel(mid_x + ox, mid_y + oy, 1'b0, fin);
      queue_pixel(mid_x + ox, mid_y - oy, 1'b0, fin);
      queue_pixel(mid_x - ox, mid_y + oy, 1'b0, fin);
      queue_pixel(mid_x - ox, mid_y - oy, 1'b1, fin);
   endfunction

   function automatic void check_field(input string name,
                                       input logic [RGBW-1:0] want, got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         color = '0;
         mid_x = '0;
         mid_y = '0;
         a_sq = '0;
         b_sq = '0;
         walk_x = '0;
         walk_y = '0;
         decision = '0;
         region_two = 1'b0;
         tracing = 1'b0;
         pending_pixels.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel transfer with none expected: x=%0d y=%0d",
                      rsp_data.pixel_x, rsp_data.pixel_y);
               error_count++;
            end else begin
               oldest = pending_pixels.pop_front();
               check_field("pixel_x", RGBW'(oldest.pixel_x), RGBW'(rsp_data.pixel_x));
               check_field("pixel_y", RGBW'(oldest.pixel_y), RGBW'(rsp_data.pixel_y));
               check_field("pixel_rgb", oldest.pixel_rgb, rsp_data.pixel_rgb);
               check_field("last_of_run", RGBW'(oldest.last_of_run),
                           RGBW'(rsp_data.last_of_run));
               check_field("finished", RGBW'(oldest.finished), RGBW'(rsp_data.finished));
            end
         end
         if (csr_wr_en)
            color = csr_wr_data;
         if (req_valid && req_ready)
            rasterize_item(req_data);
      end
      pixels_pending = pending_pixels.size();
   end

endmodule

FILE: tb/sv/midpoint_ellipse_rasterizer_tb.sv
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_tb;

   localparam int ITEM_TARGET   = 280;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam int CW            = mer_pkg::COORD_BITS;
   localparam int RGBW          = mer_pkg::RGB_BITS;
   localparam int COORD_MAX     = (1 << CW) - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mer_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mer_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [RGBW-1:0]  csr_wr_data = '0;

   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   logic hold_start = 1'b0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   items_sent = 0;
   int   error_count;
   int   pixels_pending;

   midpoint_ellipse_rasterizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   ellipse_pixel_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pixels_pending(pixels_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** midpoint_ellipse_rasterizer: FAILED **");
         $finish;
      end
   end

   // pixel sink: random back-pressure, plus one long hold on request
   always @(posedge clock) begin
      if (hold_start)
         hold_left <= LONG_HOLD;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
      rsp_ready <= !reset && !hold_start && hold_left == 0 &&
                   $urandom_range(99) >= rsp_idle_pct;
   end

   function automatic mer_pkg::req_type start_item(input int ax, ay, bx, by);
      mer_pkg::req_type r;
      r.mode      = mer_pkg::MODE_START;
      r.corner_ax = CW'(ax);
      r.corner_ay = CW'(ay);
      r.corner_bx = CW'(bx);
      r.corner_by = CW'(by);
      return r;
   endfunction

   // corner fields are don't-care on a step, so fill them with noise
   function automatic mer_pkg::req_type step_item();
      mer_pkg::req_type r;
      r = start_item($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
      r.mode = mer_pkg::MODE_STEP;
      return r;
   endfunction

   function automatic mer_pkg::req_type noise_item();
      mer_pkg::req_type r;
      r = step_item();
      r.mode = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic mer_pkg::req_type box_item(input int span_x, span_y);
      int x0, y0;
      logic [1:0] flip;
      x0 = $urandom_range(COORD_MAX - span_x);
      y0 = $urandom_range(COORD_MAX - span_y);
      flip = 2'($urandom_range(3));
      return start_item(flip[0] ? x0 + span_x : x0, flip[1] ? y0 + span_y : y0,
                        flip[0] ? x0 : x0 + span_x, flip[1] ? y0 : y0 + span_y);
   endfunction

   task automatic send_item(input mer_pkg::req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_steps(input int count);
      repeat (count) send_item(step_item());
   endtask

   task automatic run_random(input int upto);
      int span_x, span_y, full, pick;
      while (items_sent < upto) begin
         span_x = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(24);
         span_y = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(24);
         full = span_x / 2 + span_y / 2 + 2;
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_item(box_item(span_x, span_y));
            // most outlines run to completion, some get cut short by the next start
            send_steps(pick < 65 ? full : $urandom_range(full - 1));
         end else begin
            repeat ($urandom_range(1, 3)) send_item(noise_item());
         end
      end
   endtask

   // drain, then allow for a step still in flight that produces no pixels
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixels_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_color(input logic [RGBW-1:0] rgb);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rgb;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct <= 36;
      rsp_idle_pct <= 58;
      write_color('1);

      // step with no outline in progress
      send_item(step_item());
      // full-grid box, restarted on the other diagonal mid-outline
      send_item(start_item(0, 0, COORD_MAX, COORD_MAX));
      send_steps(3);
      send_item(start_item(COORD_MAX, 0, 0, COORD_MAX));
      send_steps(2);
      // zero height: top pixel is already the finished one, the step is dropped
      send_item(start_item(0, COORD_MAX, COORD_MAX, COORD_MAX));
      send_steps(1);
      // zero width, then a box one pixel tall, each drawn to the end
      send_item(start_item(501, 500, 500, 508));
      send_steps(6);
      send_item(start_item(16, 13, 10, 10));
      send_steps(6);
      run_random(ITEM_TARGET / 3);
      settle();

      write_color('0);
      req_idle_pct <= 58;
      rsp_idle_pct <= 36;
      run_random(2 * ITEM_TARGET / 3);
      settle();

      write_color(RGBW'($urandom()));
      req_idle_pct <= 0;
      rsp_idle_pct <= 0;
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      run_random(ITEM_TARGET);
      settle();

      if (error_count == 0 && pixels_pending == 0)
         $display("** midpoint_ellipse_rasterizer: PASSED **");
      else
         $display("** midpoint_ellipse_rasterizer: FAILED **");
      $finish;
   end

endmodule

FILE: files.f
hdl/mer_pkg.sv
hdl/mer_datapath.sv
hdl/mer_ctrl.sv
hdl/midpoint_ellipse_rasterizer.sv
hdl/mer_checker.sv
tb/sv/ellipse_pixel_checker.sv
tb/sv/midpoint_ellipse_rasterizer_tb.sv
